@@ design/char_lcd_refresh_controller_top_macros.svh @@
// assertion macros shared by the checker of the lcd refresh controller
`ifndef CHAR_LCD_REFRESH_CONTROLLER_TOP_MACROS_SVH
`define CHAR_LCD_REFRESH_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication, quiet during reset
`define CLRC_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define CLRC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, checked during reset as well
`define CLRC_ASSERT_NEXT_ALWAYS(name, ante, cons, msg) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/clrc_pkg.sv @@
// shared types, constants and the init command table of the lcd refresh controller
package clrc_pkg;

  // default geometry of the character buffer
  localparam int COLS_DEF = 16;
  localparam int ROWS_DEF = 2;

  // power-up wait after reset, in ticks
  localparam logic [7:0] PUP_TICKS_RST = 8'd3;

  // operation codes carried in the request kind
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_MOVE  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // display command bytes and characters
  localparam logic [7:0] CHAR_SPACE    = 8'h20;
  localparam logic [7:0] CMD_HOME      = 8'h02;
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [7:0] ROW1_OFFSET   = 8'h40;
  localparam logic [1:0] FUNC_SET_4BIT = 2'b10;

  // init sequence length
  localparam logic [3:0] INIT_LEN = 4'd9;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
    logic sel_second;
  } clrc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [1:0] res_count;
  } clrc_status_t;

  // init command table
  function automatic logic [7:0] init_cmd(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0, 4'd1, 4'd2: c = 8'h30;
      4'd3:             c = 8'h20;
      4'd4:             c = 8'h28;
      4'd5:             c = 8'h0C;
      4'd6:             c = 8'h06;
      4'd7:             c = 8'h01;
      default:          c = CMD_HOME;
    endcase
    return c;
  endfunction

endpackage

@@ design/clrc_ctrl.sv @@
// request sequencing state machine of the lcd refresh controller
module clrc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic                  m_tlast,
  output clrc_pkg::clrc_cmd_t   cmd,
  input  clrc_pkg::clrc_status_t status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_OUT0,
    S_OUT1
  } state_t;

  state_t state;
  logic   pair;
  logic   sel_second;

  assign s_tready       = (state == S_IDLE);
  assign cmd.capture    = s_tvalid && s_tready;
  assign cmd.exec       = (state == S_EXEC);
  assign cmd.sel_second = sel_second;

  // state and registered handshake outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      m_tvalid   <= 1'b0;
      m_tlast    <= 1'b0;
      pair       <= 1'b0;
      sel_second <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (status.res_count == 2'd0) begin
            state <= S_IDLE;
          end else begin
            state      <= S_OUT0;
            m_tvalid   <= 1'b1;
            m_tlast    <= (status.res_count == 2'd1);
            pair       <= (status.res_count == 2'd2);
            sel_second <= 1'b0;
          end
        end
        S_OUT0: begin
          if (m_tready) begin
            if (pair) begin
              state      <= S_OUT1;
              m_tlast    <= 1'b1;
              sel_second <= 1'b1;
            end else begin
              state    <= S_IDLE;
              m_tvalid <= 1'b0;
              m_tlast  <= 1'b0;
            end
          end
        end
        S_OUT1: begin
          if (m_tready) begin
            state      <= S_IDLE;
            m_tvalid   <= 1'b0;
            m_tlast    <= 1'b0;
            sel_second <= 1'b0;
          end
        end
        default: begin
          state    <= S_IDLE;
          m_tvalid <= 1'b0;
          m_tlast  <= 1'b0;
        end
      endcase
    end
  end

endmodule

@@ design/clrc_dp.sv @@
// buffer, cursors, display phase and nibble formation of the lcd refresh controller
module clrc_dp #(
  parameter int COLS = clrc_pkg::COLS_DEF,
  parameter int ROWS = clrc_pkg::ROWS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  clrc_pkg::clrc_cmd_t    cmd,
  output clrc_pkg::clrc_status_t status,
  input  logic [1:0]             op,
  input  logic [7:0]             char_code,
  input  logic [5:0]             target_col,
  input  logic [1:0]             target_row,
  input  logic                   cfg_we,
  input  logic [7:0]             cfg_data,
  output logic [3:0]             nibble,
  output logic                   is_data
);

  localparam int DEPTH = COLS * ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [5:0]    COLS_C = 6'(COLS);
  localparam logic [1:0]    ROWS_C = 2'(ROWS);
  localparam logic [AW-1:0] ROW1_BASE = AW'(COLS);

  typedef enum logic [1:0] {
    PH_POWER_UP,
    PH_INIT,
    PH_READY,
    PH_SET_CURSOR
  } phase_t;

  phase_t      phase;
  logic [7:0]  countdown;
  logic [3:0]  init_index;
  logic        four_bit;
  logic [5:0]  write_col;
  logic        write_row;
  logic [5:0]  refresh_col;
  logic        refresh_row;
  logic [DEPTH-1:0] valid;

  // captured request
  logic [1:0]  in_op;
  logic [7:0]  in_char;
  logic [5:0]  in_col;
  logic [1:0]  in_row;

  // character memory
  logic [7:0]  mem [DEPTH];
  logic [7:0]  rd_char;
  logic        rd_valid;

  // result registers
  logic [3:0]  res0_nib;
  logic        res0_data;
  logic [3:0]  res1_nib;
  logic        res1_data;

  logic          wr_hit;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [7:0]    char_now;
  logic [7:0]    cmd_byte;
  logic [7:0]    cursor_byte;
  logic          switch_4bit;
  logic [5:0]    col_inc;
  logic [1:0]    row_inc;
  logic          col_wrap;
  logic          row_wrap;
  logic [1:0]    count;

  // buffer addressing
  assign wr_hit  = cmd.exec && (in_op == clrc_pkg::OP_WRITE) && (write_col < COLS_C)
                   && ({1'b0, write_row} < ROWS_C);
  assign wr_addr = write_row ? (ROW1_BASE + AW'(write_col)) : AW'(write_col);
  assign rd_addr = refresh_row ? (ROW1_BASE + AW'(refresh_col)) : AW'(refresh_col);
  assign char_now = rd_valid ? rd_char : clrc_pkg::CHAR_SPACE;

  // command byte for the current phase
  assign cursor_byte = clrc_pkg::CMD_SET_DDRAM
                       + (refresh_row ? clrc_pkg::ROW1_OFFSET : 8'h00)
                       + {2'b00, refresh_col};
  always_comb begin
    if (phase == PH_INIT) begin
      cmd_byte = (init_index < clrc_pkg::INIT_LEN) ? clrc_pkg::init_cmd(init_index)
                                                    : clrc_pkg::CMD_HOME;
    end else begin
      cmd_byte = cursor_byte;
    end
  end
  assign switch_4bit = !four_bit && (cmd_byte[5:4] == clrc_pkg::FUNC_SET_4BIT);

  // refresh pointer advance
  assign col_inc  = refresh_col + 6'd1;
  assign row_inc  = {1'b0, refresh_row} + 2'd1;
  assign col_wrap = (col_inc >= COLS_C);
  assign row_wrap = (row_inc >= ROWS_C);

  // number of nibbles this request produces
  always_comb begin
    count = 2'd0;
    if (in_op == clrc_pkg::OP_TICK) begin
      case (phase)
        PH_POWER_UP:   count = 2'd0;
        PH_READY:      count = 2'd2;
        PH_INIT,
        PH_SET_CURSOR: count = four_bit ? 2'd2 : 2'd1;
        default:       count = 2'd0;
      endcase
    end
  end
  assign status.res_count = count;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_op   <= op;
      in_char <= char_code;
      in_col  <= target_col;
      in_row  <= target_row;
    end
  end

  // memory write and registered read at the refresh pointer
  always_ff @(posedge clk) begin
    if (wr_hit) begin
      mem[wr_addr] <= in_char;
    end
    rd_char  <= mem[rd_addr];
    rd_valid <= valid[rd_addr];
  end

  // nibble results
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (phase == PH_READY) begin
        res0_nib  <= char_now[7:4];
        res0_data <= 1'b1;
        res1_nib  <= char_now[3:0];
        res1_data <= 1'b1;
      end else begin
        res0_nib  <= cmd_byte[7:4];
        res0_data <= 1'b0;
        res1_nib  <= cmd_byte[3:0];
        res1_data <= 1'b0;
      end
    end
  end
  assign nibble  = cmd.sel_second ? res1_nib : res0_nib;
  assign is_data = cmd.sel_second ? res1_data : res0_data;

  // cursors, phase and link mode
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_POWER_UP;
      countdown   <= clrc_pkg::PUP_TICKS_RST;
      init_index  <= 4'd0;
      four_bit    <= 1'b0;
      write_col   <= 6'd0;
      write_row   <= 1'b0;
      refresh_col <= 6'd0;
      refresh_row <= 1'b0;
      valid       <= '0;
    end else begin
      if (cmd.exec) begin
        case (in_op)
          clrc_pkg::OP_WRITE: begin
            if (wr_hit) begin
              valid[wr_addr] <= 1'b1;
              write_col      <= write_col + 6'd1;
            end
          end
          clrc_pkg::OP_MOVE: begin
            if (in_col < COLS_C) begin
              write_col <= in_col;
            end
            if (in_row < ROWS_C) begin
              write_row <= in_row[0];
            end
          end
          clrc_pkg::OP_CLEAR: begin
            valid <= '0;
          end
          default: begin
            case (phase)
              PH_POWER_UP: begin
                countdown <= countdown - 8'd1;
                if (countdown == 8'd1) begin
                  phase      <= PH_INIT;
                  init_index <= 4'd0;
                end
              end
              PH_INIT: begin
                if (switch_4bit) begin
                  four_bit <= 1'b1;
                end
                if (init_index < clrc_pkg::INIT_LEN) begin
                  init_index <= init_index + 4'd1;
                end else begin
                  phase       <= PH_READY;
                  valid       <= '0;
                  refresh_col <= 6'd0;
                  refresh_row <= 1'b0;
                end
              end
              PH_READY: begin
                if (col_wrap) begin
                  refresh_col <= 6'd0;
                  refresh_row <= row_wrap ? 1'b0 : row_inc[0];
                  phase       <= PH_SET_CURSOR;
                end else begin
                  refresh_col <= col_inc;
                end
              end
              default: begin
                if (switch_4bit) begin
                  four_bit <= 1'b1;
                end
                phase <= PH_READY;
              end
            endcase
          end
        endcase
      end
      // power-up length reload
      if (cfg_we && (phase == PH_POWER_UP)) begin
        countdown <= cfg_data;
      end
    end
  end

endmodule

@@ design/char_lcd_refresh_controller_top.sv @@
// top level of the character lcd refresh controller
//
// Requests enter on the s_ channel: s_tuser carries the operation (tick, write
// character, move cursor, clear buffer) and s_tdata the character and target
// cursor. Ticks step the display sequence (power-up wait, init commands, then
// endless refresh of the COLS x ROWS buffer); each tick that talks to the
// display yields one or two nibbles on the m_ channel, with m_tuser as the
// register select and m_tlast on the final nibble of that tick.
// cfg_we/cfg_data reload the power-up tick count while in the power-up wait,
// restarting the countdown; writes outside the power-up wait are ignored.
// Sequencing: a request is taken in one cycle and executed in the next; the
// nibbles of a tick are registered out of the execute cycle, and each nibble
// needs one m_ handshake. The controller handles one request at a time:
// s_tready is low until every nibble of the current request has been taken,
// so a stalled receiver holds the input side.
// Reset returns to the power-up wait with a blank buffer at once; the buffer
// is blanked through per-entry valid bits, so there is no clearing pass.
module char_lcd_refresh_controller_top #(
  parameter int COLS = clrc_pkg::COLS_DEF,
  parameter int ROWS = clrc_pkg::ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // char_code[7:0], target_col[13:8], target_row[15:14]
  input  logic [1:0]  s_tuser,   // operation[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // nibble[3:0], zero[7:4]
  output logic [0:0]  m_tuser,   // is_data[0]
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data
);

  clrc_pkg::clrc_cmd_t    cmd;
  clrc_pkg::clrc_status_t status;
  logic [3:0]             nibble;
  logic                   is_data;

  // request sequencing
  clrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .cmd      (cmd),
    .status   (status)
  );

  // buffer and display sequence
  clrc_dp #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .op         (s_tuser),
    .char_code  (s_tdata[7:0]),
    .target_col (s_tdata[13:8]),
    .target_row (s_tdata[15:14]),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .nibble     (nibble),
    .is_data    (is_data)
  );

  // result packing
  assign m_tdata = {4'b0000, nibble};
  assign m_tuser = is_data;

endmodule

@@ design/clrc_checker.sv @@
// port-level checks of the lcd refresh controller and their bind
`include "char_lcd_refresh_controller_top_macros.svh"

module clrc_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [0:0] m_tuser,
  input logic       m_tlast
);

  // stalled result holds its payload
  `CLRC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

  // no new request while a result is pending
  `CLRC_ASSERT_IMPL(a_busy_no_accept, m_tvalid, !s_tready, "request taken while result pending")

  // a taken first nibble of a pair is followed by the final one
  `CLRC_ASSERT_NEXT(a_pair_follows, m_tvalid && m_tready && !m_tlast, m_tvalid && m_tlast, "second nibble missing")

  // nothing is shown in the cycle after a request is taken
  `CLRC_ASSERT_NEXT(a_exec_gap, s_tvalid && s_tready, !m_tvalid, "result without execute cycle")

  // reset clears the output side
  `CLRC_ASSERT_NEXT_ALWAYS(a_reset_idle, rst, !m_tvalid && s_tready, "output valid after reset")

endmodule

bind char_lcd_refresh_controller_top clrc_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

@@ tb/sv/testbench.sv @@
// self-checking testbench for the character lcd refresh controller
module testbench;

  localparam int COLS = clrc_pkg::COLS_DEF;
  localparam int ROWS = clrc_pkg::ROWS_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT = 2000;
  localparam int IDLE_PCT = 36;
  localparam int REPORT_MAX = 10;

  // power-on command bytes, entry 0 goes out first
  localparam logic [8:0][7:0] POWER_ON_SEQ = {
    8'h02, 8'h01, 8'h06, 8'h0C, 8'h28, 8'h20, 8'h30, 8'h30, 8'h30
  };

  typedef enum logic [1:0] {
    PH_POWER_WAIT,
    PH_INIT_SEQ,
    PH_REFRESH,
    PH_CURSOR
  } lcd_phase_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] ch;
    logic [5:0] col;
    logic [1:0] row;
  } lcd_req_t;

  typedef struct packed {
    logic [3:0] nib;
    logic       is_data;
    logic       last;
  } lcd_nibble_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // char_code[7:0], target_col[13:8], target_row[15:14]
  logic [1:0]  s_tuser = '0;   // operation[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // nibble[3:0], zero[7:4]
  logic [0:0]  m_tuser;        // is_data[0]
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_data = '0;

  char_lcd_refresh_controller_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // stimulus and expected nibble stores
  lcd_req_t    host_reqs[$];
  lcd_nibble_t expected_nibbles[$];
  lcd_nibble_t tick_burst[$];

  int sent_count = 0;
  int taken_count = 0;
  int stall_cycles = 0;
  int mismatch_count = 0;
  bit calm = 1'b0;

  // shadow state of the controller
  logic [7:0] frame_buf [COLS*ROWS];
  logic [5:0] wr_col;
  logic       wr_row;
  logic [4:0] rf_col;
  logic       rf_row;
  lcd_phase_t phase;
  logic [3:0] init_idx;
  logic [7:0] countdown;
  logic       four_bit;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void blank_frame();
    for (int i = 0; i < COLS*ROWS; i++) frame_buf[i] = clrc_pkg::CHAR_SPACE;
  endfunction

  function automatic void emit_nibble(input logic [3:0] n, input logic d);
    tick_burst.push_back('{nib: n, is_data: d, last: 1'b0});
  endfunction

  // command byte: high nibble always, low nibble only on the 4-bit link
  function automatic void emit_command(input logic [7:0] cmd);
    emit_nibble(cmd[7:4], 1'b0);
    if (four_bit) emit_nibble(cmd[3:0], 1'b0);
    else if (cmd[5:4] == clrc_pkg::FUNC_SET_4BIT) four_bit = 1'b1;
  endfunction

  // advance the shadow state by one request and queue the nibbles it yields
  function automatic void predict_nibbles(input lcd_req_t r);
    logic [7:0] c;
    tick_burst.delete();
    case (r.op)
      clrc_pkg::OP_WRITE: begin
        if (wr_col < COLS && wr_row < ROWS) begin
          frame_buf[wr_row*COLS + wr_col] = r.ch;
          wr_col = wr_col + 1'b1;
        end
      end
      clrc_pkg::OP_MOVE: begin
        if (r.col < COLS) wr_col = r.col;
        if (r.row < ROWS) wr_row = r.row[0];
      end
      clrc_pkg::OP_CLEAR: blank_frame();
      default: begin
        case (phase)
          PH_POWER_WAIT: begin
            countdown = countdown - 1'b1;
            if (countdown == 8'd0) begin
              init_idx = '0;
              phase = PH_INIT_SEQ;
            end
          end
          PH_INIT_SEQ: begin
            if (init_idx < clrc_pkg::INIT_LEN) begin
              emit_command(POWER_ON_SEQ[init_idx]);
              init_idx = init_idx + 1'b1;
            end else begin
              // end of init: home, blank buffer, restart refresh
              phase = PH_REFRESH;
              emit_command(clrc_pkg::CMD_HOME);
              blank_frame();
              rf_col = '0;
              rf_row = 1'b0;
            end
          end
          PH_REFRESH: begin
            c = clrc_pkg::CHAR_SPACE;
            if (rf_col < COLS && rf_row < ROWS) c = frame_buf[rf_row*COLS + rf_col];
            emit_nibble(c[7:4], 1'b1);
            emit_nibble(c[3:0], 1'b1);
            rf_col = rf_col + 1'b1;
            if (rf_col >= COLS) begin
              rf_col = '0;
              rf_row = (rf_row + 1 >= ROWS) ? 1'b0 : rf_row + 1'b1;
              phase = PH_CURSOR;
            end
          end
          default: begin
            emit_command(clrc_pkg::CMD_SET_DDRAM
                         + (rf_row ? clrc_pkg::ROW1_OFFSET : 8'h00) + {3'b000, rf_col});
            phase = PH_REFRESH;
          end
        endcase
      end
    endcase
    if (tick_burst.size() > 0) tick_burst[tick_burst.size()-1].last = 1'b1;
    foreach (tick_burst[i]) expected_nibbles.push_back(tick_burst[i]);
  endfunction

  function automatic void flag_mismatch(input string what);
    if (mismatch_count < REPORT_MAX) $display("mismatch: %s", what);
    mismatch_count++;
  endfunction

  // request driver, fed from host_reqs
  always @(negedge clk) begin
    lcd_req_t r;
    if (!rst && sent_count == taken_count) begin
      if (host_reqs.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        r = host_reqs.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= r.op;
        s_tdata <= {r.row, r.col, r.ch};
        sent_count = sent_count + 1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // monitor: check nibbles, track config writes, predict on each request
  always @(posedge clk) begin
    lcd_nibble_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_nibbles.size() == 0) begin
          flag_mismatch($sformatf("unexpected nibble data=%h rs=%b last=%b",
                                  m_tdata, m_tuser, m_tlast));
        end else begin
          want = expected_nibbles.pop_front();
          if (m_tdata !== {4'h0, want.nib} || m_tuser[0] !== want.is_data ||
              m_tlast !== want.last)
            flag_mismatch($sformatf("exp data=%h rs=%b last=%b, got data=%h rs=%b last=%b",
                                    {4'h0, want.nib}, want.is_data, want.last,
                                    m_tdata, m_tuser, m_tlast));
        end
      end
      if (cfg_we) begin
        if (phase == PH_POWER_WAIT) countdown = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        predict_nibbles('{op: s_tuser, ch: s_tdata[7:0], col: s_tdata[13:8],
                          row: s_tdata[15:14]});
        taken_count <= taken_count + 1;
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  // watchdog on cycles with no transfer at all
  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("char_lcd_refresh_controller_top verification failed");
    $finish;
  end

  function automatic void queue_req(input logic [1:0] op, input logic [7:0] ch,
                                    input logic [5:0] col, input logic [1:0] row);
    host_reqs.push_back('{op: op, ch: ch, col: col, row: row});
  endfunction

  task automatic write_cfg(input logic [7:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // hold off until every request is taken and every nibble has come back
  task automatic drain();
    do @(posedge clk);
    while (host_reqs.size() != 0 || sent_count != taken_count ||
           expected_nibbles.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly ticks and writes, moves mostly inside the row, rare clears
  task automatic run_random_phase(input int n);
    lcd_req_t r;
    int pick;
    for (int i = 0; i < n; i++) begin
      r.ch = 8'($urandom_range(255));
      r.col = 6'($urandom_range(63));
      r.row = 2'($urandom_range(3));
      pick = int'($urandom_range(99));
      if (pick < 50) r.op = clrc_pkg::OP_TICK;
      else if (pick < 80) r.op = clrc_pkg::OP_WRITE;
      else if (pick < 97) begin
        r.op = clrc_pkg::OP_MOVE;
        if ($urandom_range(9) < 7) r.col = 6'($urandom_range(COLS-1));
      end else r.op = clrc_pkg::OP_CLEAR;
      host_reqs.push_back(r);
    end
  endtask

  initial begin
    logic [7:0] cfg_vals [5];
    cfg_vals = '{8'd255, 8'd1, 8'd3, 8'd128, 8'd0};
    cfg_vals[4] = 8'($urandom_range(255, 1));

    // shadow state after reset
    blank_frame();
    wr_col = '0;
    wr_row = 1'b0;
    rf_col = '0;
    rf_row = 1'b0;
    phase = PH_POWER_WAIT;
    init_idx = '0;
    countdown = clrc_pkg::PUP_TICKS_RST;
    four_bit = 1'b0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // power-up wait: long count, a few ticks and host activity, then reload to one
    write_cfg(8'd255);
    repeat (3) queue_req(clrc_pkg::OP_TICK, 8'h00, 6'd0, 2'd0);
    queue_req(clrc_pkg::OP_WRITE, 8'hFF, 6'd0, 2'd0);
    queue_req(clrc_pkg::OP_MOVE, 8'h00, 6'd15, 2'd1);
    queue_req(clrc_pkg::OP_WRITE, 8'h00, 6'd0, 2'd0);
    drain();
    write_cfg(8'd1);

    // init sequence, a write lost at init end, then row-end and range cases
    queue_req(clrc_pkg::OP_TICK, 8'h00, 6'd0, 2'd0);
    repeat (5) queue_req(clrc_pkg::OP_TICK, 8'h00, 6'd0, 2'd0);
    queue_req(clrc_pkg::OP_WRITE, 8'h41, 6'd0, 2'd0);
    repeat (5) queue_req(clrc_pkg::OP_TICK, 8'h00, 6'd0, 2'd0);
    queue_req(clrc_pkg::OP_WRITE, 8'h00, 6'd0, 2'd0);
    queue_req(clrc_pkg::OP_WRITE, 8'hFF, 6'd0, 2'd0);
    queue_req(clrc_pkg::OP_MOVE, 8'h00, 6'd15, 2'd1);
    queue_req(clrc_pkg::OP_WRITE, 8'h5A, 6'd0, 2'd0);
    queue_req(clrc_pkg::OP_WRITE, 8'h3C, 6'd0, 2'd0);
    queue_req(clrc_pkg::OP_MOVE, 8'hFF, 6'd63, 2'd3);
    queue_req(clrc_pkg::OP_TICK, 8'hFF, 6'd63, 2'd3);
    queue_req(clrc_pkg::OP_TICK, 8'h00, 6'd0, 2'd0);
    queue_req(clrc_pkg::OP_CLEAR, 8'h00, 6'd0, 2'd0);
    queue_req(clrc_pkg::OP_TICK, 8'h00, 6'd0, 2'd0);
    drain();

    // random phases, one of them without any idling
    for (int p = 0; p < 5; p++) begin
      write_cfg(cfg_vals[p]);
      calm = (p == 2);
      run_random_phase(400);
      drain();
    end

    if (mismatch_count == 0 && expected_nibbles.size() == 0) begin
      $display("char_lcd_refresh_controller_top verification clean");
    end else begin
      $display("char_lcd_refresh_controller_top verification failed");
    end
    $finish;
  end

endmodule
